// ----- sv/rnwp_pkg.sv -----
// ----------------------------------------------------------------------------
// rnwp_pkg
// types, dictionary table and constants of the numeral word parser
// ----------------------------------------------------------------------------
package rnwp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [30:0] number_value;
    logic        saturated;
  } out_item_t;

  localparam int DICT_SIZE  = 41;
  localparam int DICT_IDX_W = 6;
  localparam int SPELL_MAX  = 12;
  localparam logic [30:0] TOTAL_MAX = 31'h7FFF_FFFF;
  localparam logic [9:0]  SCALE_FACTOR = 10'd1000;

  // one letter code per character, see cyr_second
  typedef struct packed {
    logic [SPELL_MAX*8-1:0] spell;   // ascii, first letter in low byte
    logic [3:0]             letters;
    logic [9:0]             value;
    logic                   is_scale;
  } dict_entry_t;

  function automatic logic [7:0] cyr_second(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      "a": r = 8'hB0; "v": r = 8'hB2; "d": r = 8'hB4; "e": r = 8'hB5;
      "i": r = 8'hB8; "k": r = 8'hBA; "m": r = 8'hBC; "n": r = 8'hBD;
      "o": r = 8'hBE; "p": r = 8'hBF; "r": r = 8'h80; "s": r = 8'h81;
      "t": r = 8'h82; "c": r = 8'h86; "h": r = 8'h87; "w": r = 8'h88;
      "y": r = 8'h8B; "x": r = 8'h8C;
      default: r = 8'h8F;
    endcase
    return r;
  endfunction

  function automatic logic [SPELL_MAX*8-1:0] rev(input string s);
    logic [SPELL_MAX*8-1:0] r;
    r = '0;
    for (int k = 0; k < s.len(); k++) r[k*8 +: 8] = s[k];
    return r;
  endfunction

  function automatic dict_entry_t mk(input string s, input int v, input logic sc);
    dict_entry_t e;
    e.spell    = rev(s);
    e.letters  = 4'(s.len());
    e.value    = 10'(v);
    e.is_scale = sc;
    return e;
  endfunction

  function automatic dict_entry_t dict_at(input logic [DICT_IDX_W-1:0] i);
    dict_entry_t e;
    case (i)
      6'd0:  e = mk("odin", 1, 1'b0);
      6'd1:  e = mk("odna", 1, 1'b0);
      6'd2:  e = mk("dva", 2, 1'b0);
      6'd3:  e = mk("dve", 2, 1'b0);
      6'd4:  e = mk("tri", 3, 1'b0);
      6'd5:  e = mk("hetyre", 4, 1'b0);
      6'd6:  e = mk("pqtx", 5, 1'b0);
      6'd7:  e = mk("westx", 6, 1'b0);
      6'd8:  e = mk("semx", 7, 1'b0);
      6'd9:  e = mk("vosemx", 8, 1'b0);
      6'd10: e = mk("devqtx", 9, 1'b0);
      6'd11: e = mk("desqtx", 10, 1'b0);
      6'd12: e = mk("odinnadcatx", 11, 1'b0);
      6'd13: e = mk("dvenadcatx", 12, 1'b0);
      6'd14: e = mk("trinadcatx", 13, 1'b0);
      6'd15: e = mk("hetyrnadcatx", 14, 1'b0);
      6'd16: e = mk("pqtnadcatx", 15, 1'b0);
      6'd17: e = mk("westnadcatx", 16, 1'b0);
      6'd18: e = mk("semnadcatx", 17, 1'b0);
      6'd19: e = mk("vosemnadcatx", 18, 1'b0);
      6'd20: e = mk("devqtnadcatx", 19, 1'b0);
      6'd21: e = mk("dvadcatx", 20, 1'b0);
      6'd22: e = mk("tridcatx", 30, 1'b0);
      6'd23: e = mk("sorok", 40, 1'b0);
      6'd24: e = mk("pqtxdesqt", 50, 1'b0);
      6'd25: e = mk("westxdesqt", 60, 1'b0);
      6'd26: e = mk("semxdesqt", 70, 1'b0);
      6'd27: e = mk("vosemxdesqt", 80, 1'b0);
      6'd28: e = mk("devqnosto", 90, 1'b0);
      6'd29: e = mk("sto", 100, 1'b0);
      6'd30: e = mk("dvesti", 200, 1'b0);
      6'd31: e = mk("trista", 300, 1'b0);
      6'd32: e = mk("hetyresta", 400, 1'b0);
      6'd33: e = mk("pqtxsot", 500, 1'b0);
      6'd34: e = mk("westxsot", 600, 1'b0);
      6'd35: e = mk("semxsot", 700, 1'b0);
      6'd36: e = mk("vosemxsot", 800, 1'b0);
      6'd37: e = mk("devqtxsot", 900, 1'b0);
      6'd38: e = mk("tysqha", 1000, 1'b1);
      6'd39: e = mk("tysqhi", 1000, 1'b1);
      6'd40: e = mk("tysqh", 1000, 1'b1);
      default: e = mk("", 0, 1'b0);
    endcase
    return e;
  endfunction

  // controller to datapath
  typedef struct packed {
    logic take_byte;
    logic start_match;
    logic cmp_step;
    logic next_word;
    logic apply;
    logic mul_step;
    logic emit;
    logic clear_total;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_last;
    logic need_close;
    logic need_match;
    logic word_done;
    logic word_hit;
    logic dict_end;
    logic hit_scale;
  } dp_stat_t;

endpackage

// ----- sv/rnwp_datapath.sv -----
// ----------------------------------------------------------------------------
// rnwp_datapath
// token store, letter-serial dictionary compare and clamped total
// ----------------------------------------------------------------------------
module rnwp_datapath #(
  parameter int MAX_TOKEN_BYTES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  rnwp_pkg::in_item_t in_item,
  input  rnwp_pkg::dp_cmd_t  cmd,
  output rnwp_pkg::dp_stat_t stat,
  output rnwp_pkg::out_item_t res
);
  import rnwp_pkg::*;

  localparam int AW = $clog2(MAX_TOKEN_BYTES);
  localparam int LW = $clog2(MAX_TOKEN_BYTES + 1);

  logic [7:0]     token_store [MAX_TOKEN_BYTES];
  logic [LW-1:0]  token_length;
  logic           token_overlong;
  logic [30:0]    running_total;
  logic           total_clamped;
  logic [7:0]     cur_byte;
  logic           cur_last;
  logic [DICT_IDX_W-1:0] word;
  logic [3:0]     letter;
  logic           mismatch;
  logic [7:0]     rd_lead;
  logic [7:0]     rd_second;
  logic [40:0]    prod;

  dict_entry_t ent;
  logic [7:0]  ch;
  logic [7:0]  sec;
  logic [7:0]  lead;
  logic        is_space;
  logic [LW:0] pos;
  logic [31:0] sum;

  always_comb begin
    ent  = dict_at(word);
    ch   = ent.spell[letter*8 +: 8];
    sec  = cyr_second(ch);
    lead = (sec >= 8'hB0) ? 8'hD0 : 8'hD1;
    pos  = (LW+1)'({letter, 1'b0});
    is_space = (cur_byte == 8'h20) || (cur_byte >= 8'h09 && cur_byte <= 8'h0D);
    sum  = {1'b0, running_total} + {22'd0, ent.value};
  end

  assign stat.is_last    = cur_last;
  assign stat.need_close = is_space;
  assign stat.need_match = (token_length != '0) && !token_overlong;
  assign stat.word_done  = mismatch || (letter == ent.letters);
  assign stat.word_hit   = !mismatch && (letter == ent.letters) &&
                           ((LW+1)'(token_length) == pos);
  assign stat.dict_end   = (word == DICT_IDX_W'(DICT_SIZE - 1));
  assign stat.hit_scale  = ent.is_scale;

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      cur_byte <= in_item.data_byte;
      cur_last <= in_item.last;
    end
    rd_lead   <= token_store[AW'(pos)];
    rd_second <= token_store[AW'(pos + (LW+1)'(1))];
    prod      <= {10'd0, ((running_total == '0) ? 31'd1 : running_total)} *
                 {31'd0, SCALE_FACTOR};
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && !is_space && token_length < LW'(MAX_TOKEN_BYTES))
      token_store[AW'(token_length)] <= cur_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_length   <= '0;
      token_overlong <= 1'b0;
      running_total  <= '0;
      total_clamped  <= 1'b0;
      word           <= '0;
      letter         <= '0;
      mismatch       <= 1'b0;
    end else begin
      if (cmd.start_match || cmd.next_word) begin
        word     <= cmd.start_match ? '0 : word + DICT_IDX_W'(1);
        letter   <= '0;
        mismatch <= 1'b0;
      end else if (cmd.cmp_step) begin
        if ((LW+1)'(token_length) < pos + (LW+1)'(2) || rd_lead != lead ||
            rd_second != sec)
          mismatch <= 1'b1;
        else
          letter <= letter + 4'd1;
      end
      if (cmd.mul_step) begin
        if (prod > {10'd0, TOTAL_MAX}) begin
          running_total <= TOTAL_MAX;
          total_clamped <= 1'b1;
        end else begin
          running_total <= prod[30:0];
        end
      end else if (cmd.next_word && stat.word_hit && !ent.is_scale) begin
        if (sum > {1'b0, TOTAL_MAX}) begin
          running_total <= TOTAL_MAX;
          total_clamped <= 1'b1;
        end else begin
          running_total <= sum[30:0];
        end
      end
      if (cmd.apply) begin
        if (is_space) begin
          token_length   <= '0;
          token_overlong <= 1'b0;
        end else if (token_length < LW'(MAX_TOKEN_BYTES)) begin
          token_length <= token_length + LW'(1);
        end else begin
          token_overlong <= 1'b1;
        end
      end
      if (cmd.emit) begin
        token_length   <= '0;
        token_overlong <= 1'b0;
        res.number_value <= running_total;
        res.saturated    <= total_clamped;
      end
      if (cmd.clear_total) begin
        running_total <= '0;
        total_clamped <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/rnwp_ctrl.sv -----
// ----------------------------------------------------------------------------
// rnwp_ctrl
// sequencer: byte intake, dictionary scan, total update and result handoff
// ----------------------------------------------------------------------------
module rnwp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  rnwp_pkg::dp_stat_t stat,
  output rnwp_pkg::dp_cmd_t  cmd
);
  import rnwp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_FINAL = 3'd6;

  logic [2:0] state, state_next;
  logic       closing_last, closing_last_next;
  logic       out_valid_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    closing_last_next = closing_last;
    out_valid_next = out_valid && out_stall;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.need_close && stat.need_match) begin
          closing_last_next = 1'b0;
          cmd.start_match = 1'b1;
          state_next = S_READ;
        end else begin
          cmd.apply = 1'b1;
          state_next = stat.is_last ? S_FINAL : S_IDLE;
        end
      end
      S_FINAL: begin
        if (stat.need_match) begin
          closing_last_next = 1'b1;
          cmd.start_match = 1'b1;
          state_next = S_READ;
        end else begin
          state_next = S_OUT;
        end
      end
      S_READ: state_next = S_CMP;
      S_CMP: begin
        if (stat.word_done) begin
          if (stat.word_hit && stat.hit_scale) begin
            state_next = S_MUL;
          end else if (stat.word_hit || stat.dict_end) begin
            cmd.next_word = 1'b1;
            state_next = closing_last ? S_OUT : S_DEC;
            if (!closing_last) cmd.apply = 1'b1;
            if (!closing_last) state_next = stat.is_last ? S_FINAL : S_IDLE;
          end else begin
            cmd.next_word = 1'b1;
            state_next = S_READ;
          end
        end else begin
          cmd.cmp_step = 1'b1;
          state_next = S_READ;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (closing_last) begin
          state_next = S_OUT;
        end else begin
          cmd.apply = 1'b1;
          state_next = stat.is_last ? S_FINAL : S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.emit = 1'b1;
          cmd.clear_total = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      closing_last <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      closing_last <= closing_last_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_emit_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall)) else $error("result overwritten");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take_byte, cmd.start_match, cmd.cmp_step, cmd.emit}))
    else $error("conflicting commands");
`endif

endmodule

// ----- sv/russian_number_words_parser.sv -----
// ----------------------------------------------------------------------------
// russian_number_words_parser
// splits a utf-8 byte stream into words and sums russian numeral words;
// a thousand word multiplies the total so far (or 1 if it is zero) by 1000
// channel   dir  handshake           payload
// in        in   in_valid/in_stall   data_byte, last
// out       out  out_valid/out_stall number_value, saturated
//
// a byte inside a word is taken in S_IDLE and applied in S_DEC, and no new
// byte is taken until then; a closing word is compared against each dictionary
// entry one letter a step (S_READ, S_CMP) against the token store read port
// rst is synchronous and clears the token and the total
// a result waits in its register; the next string is accepted meanwhile
// ----------------------------------------------------------------------------
module russian_number_words_parser #(
  parameter int MAX_TOKEN_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rnwp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rnwp_pkg::out_item_t out_item
);
  import rnwp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rnwp_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  rnwp_datapath #(.MAX_TOKEN_BYTES(MAX_TOKEN_BYTES)) u_dp (
    .clk, .rst, .in_item, .cmd, .stat, .res(out_item)
  );

endmodule

// ----- sim/russian_number_words_parser_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// russian_number_words_parser_checker
// watches both channels, predicts the parsed total of every string and
// compares each result item field by field with the oldest prediction
// ----------------------------------------------------------------------------
module russian_number_words_parser_checker #(
  parameter int MAX_TOKEN_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  rnwp_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  rnwp_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending
);
  import rnwp_pkg::*;

  logic [7:0]  word_buf [MAX_TOKEN_BYTES];
  int          word_len;
  bit          word_long;
  logic [31:0] sum;
  bit          clamped;
  out_item_t   totals_due [$];

  function automatic logic [7:0] letter_code(input logic [7:0] c);
    case (c)
      "a": return 8'hB0; "v": return 8'hB2; "d": return 8'hB4; "e": return 8'hB5;
      "i": return 8'hB8; "k": return 8'hBA; "m": return 8'hBC; "n": return 8'hBD;
      "o": return 8'hBE; "p": return 8'hBF; "r": return 8'h80; "s": return 8'h81;
      "t": return 8'h82; "c": return 8'h86; "h": return 8'h87; "w": return 8'h88;
      "y": return 8'h8B; "x": return 8'h8C;
      default: return 8'h8F;
    endcase
  endfunction

  function automatic bit word_is(input string s);
    logic [7:0] sec;
    if (word_len != 2 * s.len()) return 0;
    for (int k = 0; k < s.len(); k++) begin
      sec = letter_code(s[k]);
      if (word_buf[2*k] != ((sec >= 8'hB0) ? 8'hD0 : 8'hD1)) return 0;
      if (word_buf[2*k+1] != sec) return 0;
    end
    return 1;
  endfunction

  task automatic close_word();
    string words [41] = '{"odin","odna","dva","dve","tri","hetyre","pqtx","westx",
      "semx","vosemx","devqtx","desqtx","odinnadcatx","dvenadcatx","trinadcatx",
      "hetyrnadcatx","pqtnadcatx","westnadcatx","semnadcatx","vosemnadcatx",
      "devqtnadcatx","dvadcatx","tridcatx","sorok","pqtxdesqt","westxdesqt",
      "semxdesqt","vosemxdesqt","devqnosto","sto","dvesti","trista","hetyresta",
      "pqtxsot","westxsot","semxsot","vosemxsot","devqtxsot","tysqha","tysqhi",
      "tysqh"};
    int vals [41] = '{1,1,2,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17,18,19,20,30,
      40,50,60,70,80,90,100,200,300,400,500,600,700,800,900,1000,1000,1000};
    logic [63:0] p;
    if (word_len != 0 && !word_long) begin
      for (int i = 0; i < 41; i++) begin
        if (word_is(words[i])) begin
          if (i >= 38) begin
            if (sum == 0) sum = 1;
            p = 64'(sum) * 1000;
          end else begin
            p = 64'(sum) + vals[i];
          end
          if (p > 64'h7FFF_FFFF) begin
            p = 64'h7FFF_FFFF;
            clamped = 1;
          end
          sum = p[31:0];
          break;
        end
      end
    end
    word_len = 0;
    word_long = 0;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    word_len = 0;
    word_long = 0;
    sum = 0;
    clamped = 0;
  end

  always @(posedge clk) begin
    out_item_t w;
    logic [7:0] b;
    if (!rst && in_valid && !in_stall) begin
      b = in_item.data_byte;
      if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) close_word();
      else if (word_len < MAX_TOKEN_BYTES) begin
        word_buf[word_len] = b;
        word_len++;
      end else word_long = 1;
      if (in_item.last) begin
        close_word();
        w.number_value = sum[30:0];
        w.saturated = clamped;
        totals_due = {totals_due, w};
        sum = 0;
        clamped = 0;
      end
    end
    if (!rst && out_valid && !out_stall) begin
      if (totals_due.size() == 0) report("unexpected item", out_item, 0);
      else begin
        w = totals_due.pop_front();
        if (out_item.number_value != w.number_value)
          report("number_value", out_item.number_value, w.number_value);
        if (out_item.saturated != w.saturated)
          report("saturated", out_item.saturated, w.saturated);
      end
    end
    pending = totals_due.size();
  end
endmodule

// ----- sim/russian_number_words_parser_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// russian_number_words_parser_test
// drives strings of numeral words, noise and whitespace in bursts while the
// result side stalls at random; a checker beside the block scores results
// ----------------------------------------------------------------------------
module russian_number_words_parser_test;
  import rnwp_pkg::*;

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        sent = 0;
  logic [7:0] text [$];
  int        stall_mode = 0;

  always #1 clk = ~clk;

  russian_number_words_parser DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );

  russian_number_words_parser_checker CHK (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ($urandom_range(0, 20) == 0) ? ~out_stall : out_stall;
    endcase
    if ($urandom_range(0, 200) == 0) stall_mode <= $urandom_range(0, 3);
  end

  function automatic string word_of(input int v);
    case (v)
      0: return "odin"; 1: return "dva"; 2: return "tri"; 3: return "hetyre";
      4: return "desqtx"; 5: return "odinnadcatx"; 6: return "devqtnadcatx";
      7: return "dvadcatx"; 8: return "devqnosto"; 9: return "sto";
      10: return "devqtxsot"; 11: return "tysqha"; 12: return "tysqhi";
      13: return "tysqh"; 14: return "odna"; 15: return "dve";
      16: return "pqtxdesqt"; 17: return "sorok"; 18: return "hetyrnadcatx";
      19: return "semxsot"; 20: return "vosemx"; 21: return "trista";
      default: return "westx";
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b);
    text = {text, b};
  endtask

  task automatic add_word(input string s);
    logic [7:0] sec;
    for (int k = 0; k < s.len(); k++) begin
      sec = CHK.letter_code(s[k]);
      put_byte((sec >= 8'hB0) ? 8'hD0 : 8'hD1);
      put_byte(sec);
    end
  endtask

  task automatic add_space();
    int r;
    r = $urandom_range(0, 6);
    put_byte(r == 6 ? 8'h20 : 8'(8'h08 + r));
    if (r == 0) text[$] = 8'h20;
  endtask

  // one item; the last flag goes on the final byte of the string
  task automatic send_byte(input logic [7:0] b, input logic lst);
    in_valid <= 1;
    in_item.data_byte <= b;
    in_item.last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_text();
    logic [7:0] b;
    int n;
    n = text.size();
    for (int i = 0; i < n; i++) begin
      b = text.pop_front();
      send_byte(b, i == n - 1);
    end
  endtask

  task automatic build_random();
    int n;
    int kind;
    n = $urandom_range(1, 7);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) add_word(word_of($urandom_range(0, 22)));
      else if (kind == 7) begin
        repeat ($urandom_range(1, 40)) put_byte(8'($urandom_range(0, 255)));
      end else if (kind == 8) begin
        add_word(word_of($urandom_range(0, 22)));
        put_byte(8'($urandom_range(0, 255)));
      end else repeat ($urandom_range(30, 36)) put_byte(8'hD0);
      repeat ($urandom_range(1, 2)) add_space();
    end
    if ($urandom_range(0, 1)) void'(text.pop_back());
  endtask

  initial begin
    int strings;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty, a lone space, thousand forms, overflow, overlong
    send_byte(8'h20, 1);
    send_byte(8'h00, 1);
    send_byte(8'hFF, 1);
    add_word("tysqh"); add_space(); add_word("tysqha"); add_space();
    add_word("tysqhi"); add_space(); add_word("tysqh"); send_text();
    add_word("devqtxsot"); put_byte(8'h09); add_word("odinnadcatx");
    put_byte(8'h0D); add_word("tysqha"); put_byte(8'h0A);
    add_word("tysqha"); put_byte(8'h0B); add_word("sto"); put_byte(8'h0C);
    send_text();
    repeat (33) put_byte(8'hD0); put_byte(8'h20); add_word("dva");
    send_text();
    add_word("hetyre"); put_byte(8'h20); put_byte(8'h20); send_byte(8'h20, 0);
    send_text();
    // idle hold until every total is back
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    strings = 0;
    while (sent < 1750 || strings < 40) begin
      build_random();
      if (text.size() == 0) put_byte(8'($urandom_range(0, 255)));
      send_text();
      strings++;
      if ($urandom_range(0, 3) == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
      if (strings == 100) begin
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (fail_count == 0) $display("russian_number_words_parser_test: clean");
    else $display("russian_number_words_parser_test: errors");
    $finish;
  end

  initial begin
    #20000000;
    $display("russian_number_words_parser_test: errors");
    $finish;
  end
endmodule
